// File: hw/rtl/ffra_pkg.sv
// ffra_pkg: shared widths, status codes and parameter defaults for the
// first-fit region allocator; no dependencies
package ffra_pkg;

	localparam int unsigned MAX_REGIONS_DEF  = 64;
	localparam int unsigned HEADER_BYTES_DEF = 8;
	localparam int unsigned OFFSET_BITS_DEF  = 24;

	localparam int unsigned ADDR_W  = 32;
	localparam int unsigned SIZE_W  = 24;
	localparam int unsigned LIMIT_W = 24;
	localparam int unsigned GROW_W  = 26;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned PADDR_W = 3;
	localparam int unsigned PDATA_W = 32;

	localparam logic [LIMIT_W-1:0] HEAP_LIMIT_RST = LIMIT_W'(1048576);

	// request kinds
	localparam logic FN_ALLOC = 1'b0;
	localparam logic FN_FREE  = 1'b1;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOMEM   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADADDR = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd3;

	// register indexes (paddr word select)
	localparam logic REG_HEAP_BASE  = 1'b0;
	localparam logic REG_HEAP_LIMIT = 1'b1;

endpackage

// File: hw/rtl/first_fit_region_allocator.sv
// first_fit_region_allocator: first-fit region allocator without splitting
// depends on ffra_pkg
//
//  channel   signals                                       direction
//  request   in_valid/in_ready, func, size, address        in
//  result    out_valid/out_ready, address_res, status      out
//  config    psel/penable/pwrite/paddr/pwdata/prdata/pready  apb slave
//
// a request walks the region table one entry per cycle through a single registered
// read port and one shared compare unit; a hit ends the walk, while a walk that finds
// nothing passes through a decide state that appends a new region or reports the
// error, and either result then goes on to the output register
// reset clears the table count, the break and the heap base and loads the heap limit default; entries are never cleared
// in_ready is high only while idle; a result waits in the output register while the next
// request walks, which then holds in its last state until that register frees
module first_fit_region_allocator #(
	parameter int unsigned MAX_REGIONS  = ffra_pkg::MAX_REGIONS_DEF,
	parameter int unsigned HEADER_BYTES = ffra_pkg::HEADER_BYTES_DEF,
	parameter int unsigned OFFSET_BITS  = ffra_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           func,
	input  logic [ffra_pkg::SIZE_W-1:0]    size,
	input  logic [ffra_pkg::ADDR_W-1:0]    address,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ffra_pkg::ADDR_W-1:0]    address_res,
	output logic [ffra_pkg::STAT_W-1:0]    status,
	// configuration port
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [ffra_pkg::PADDR_W-1:0]   paddr,
	input  logic [ffra_pkg::PDATA_W-1:0]   pwdata,
	output logic [ffra_pkg::PDATA_W-1:0]   prdata,
	output logic                           pready
);
	import ffra_pkg::*;

	localparam int unsigned IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
	localparam int unsigned CNT_W = $clog2(MAX_REGIONS + 1);

	// sequencer states
	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_WALK   = 2'd1;
	localparam logic [1:0] S_DECIDE = 2'd2;
	localparam logic [1:0] S_OUT    = 2'd3;

	// configuration registers
	logic [ADDR_W-1:0]  heap_base_q;
	logic [LIMIT_W-1:0] heap_limit_q;

	// allocator state
	logic [CNT_W-1:0]   count_q;
	logic [LIMIT_W-1:0] break_q;

	// region table
	logic [OFFSET_BITS-1:0] off_mem  [MAX_REGIONS];
	logic [SIZE_W-1:0]      size_mem [MAX_REGIONS];
	logic                   free_mem [MAX_REGIONS];

	// sequencer and latched request
	logic [1:0]         state_q;
	logic               func_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ADDR_W-1:0]  address_q;
	logic [ADDR_W-1:0]  base_h_q;
	logic [CNT_W-1:0]   idx_q;
	logic               pend_q;
	logic [IDX_W-1:0]   ridx_q;

	// registered table read
	logic [OFFSET_BITS-1:0] off_rd_q;
	logic [SIZE_W-1:0]      size_rd_q;
	logic                   free_rd_q;

	// pending result and output register
	logic [ADDR_W-1:0]  res_addr_q;
	logic [STAT_W-1:0]  res_stat_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  out_addr_q;
	logic [STAT_W-1:0]  out_stat_q;

	logic               cfg_wr;
	logic               accept;
	logic               rd_en;
	logic [ADDR_W-1:0]  cand_addr;
	logic               hit;
	logic [GROW_W-1:0]  grown;
	logic               nomem;
	logic               full;
	logic               append;
	logic [OFFSET_BITS-1:0] new_off;

	// apb port, writes complete in the access phase
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite;

	always_comb begin
		case (paddr[2])
			REG_HEAP_BASE:  prdata = heap_base_q;
			REG_HEAP_LIMIT: prdata = PDATA_W'(heap_limit_q);
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q  <= '0;
			heap_limit_q <= HEAP_LIMIT_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_HEAP_BASE) begin
				heap_base_q <= pwdata;
			end else begin
				heap_limit_q <= pwdata[LIMIT_W-1:0];
			end
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid & in_ready;

	// shared compare unit: payload address of the entry just read
	assign cand_addr = base_h_q + ADDR_W'(off_rd_q);

	always_comb begin
		hit = 1'b0;
		if (state_q == S_WALK && pend_q) begin
			if (func_q == FN_FREE) begin
				hit = (cand_addr == address_q);
			end else begin
				hit = free_rd_q && (size_q <= size_rd_q);
			end
		end
	end

	// read the next entry while the walk continues
	assign rd_en = (state_q == S_WALK) && (idx_q < count_q) && !hit;

	// append path, checked after the walk finds nothing
	assign grown   = GROW_W'(break_q) + GROW_W'(HEADER_BYTES) + GROW_W'(size_q);
	assign nomem   = grown > GROW_W'(heap_limit_q);
	assign full    = (count_q == CNT_W'(MAX_REGIONS));
	assign append  = (state_q == S_DECIDE) && (func_q == FN_ALLOC) && !nomem && !full;
	assign new_off = OFFSET_BITS'(break_q);

	// region table write and read ports
	always_ff @(posedge clk) begin
		if (hit) begin
			free_mem[ridx_q] <= func_q;
		end else if (append) begin
			off_mem[count_q[IDX_W-1:0]]  <= new_off;
			size_mem[count_q[IDX_W-1:0]] <= size_q;
			free_mem[count_q[IDX_W-1:0]] <= 1'b0;
		end
		if (rd_en) begin
			off_rd_q  <= off_mem[idx_q[IDX_W-1:0]];
			size_rd_q <= size_mem[idx_q[IDX_W-1:0]];
			free_rd_q <= free_mem[idx_q[IDX_W-1:0]];
			ridx_q    <= idx_q[IDX_W-1:0];
		end
	end

	// latched request and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= func;
			size_q    <= size;
			address_q <= address;
			base_h_q  <= heap_base_q + ADDR_W'(HEADER_BYTES);
		end
		if (hit) begin
			res_addr_q <= (func_q == FN_FREE) ? '0 : cand_addr;
			res_stat_q <= ST_OK;
		end else if (state_q == S_DECIDE) begin
			if (func_q == FN_FREE) begin
				res_addr_q <= '0;
				res_stat_q <= ST_BADADDR;
			end else if (nomem) begin
				res_addr_q <= '0;
				res_stat_q <= ST_NOMEM;
			end else if (full) begin
				res_addr_q <= '0;
				res_stat_q <= ST_FULL;
			end else begin
				res_addr_q <= base_h_q + ADDR_W'(new_off);
				res_stat_q <= ST_OK;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
			break_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						idx_q   <= '0;
						pend_q  <= 1'b0;
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					pend_q <= rd_en;
					if (rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (hit) begin
						state_q <= S_OUT;
					end else if (!pend_q && idx_q == count_q) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (append) begin
						count_q <= count_q + 1'b1;
						break_q <= grown[LIMIT_W-1:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// output register, loaded once the previous result has left
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_addr_q <= res_addr_q;
			out_stat_q <= res_stat_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign address_res = out_addr_q;
	assign status      = out_stat_q;

endmodule
